// ----- src/posdq_pkg.sv -----
// Shared constants, codes and types of the positional insert deque.
package posdq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT       = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// What a cell loads at the next edge.
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_NEW   = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	typedef struct packed {
		logic      en;
		cell_sel_t sel;
	} cell_ctrl_t;

endpackage

// ----- src/posdq_cell.sv -----
// One storage cell of the deque chain: holds a value, loads a new one or takes one from a neighbor.
module posdq_cell
	import posdq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] new_value,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic signed [DATA_W-1:0] right_value,
	output logic signed [DATA_W-1:0] value
);

	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.sel)
				SEL_NEW:   value_q <= new_value;
				SEL_LEFT:  value_q <= left_value;
				SEL_RIGHT: value_q <= right_value;
				default:   value_q <= value_q;
			endcase
		end
	end

	assign value = value_q;

endmodule

// ----- src/positional_insert_deque.sv -----
// Top level of the positional insert deque: control, cell chain and result register.
// A result is registered and appears in the cycle after its operation is transferred in.
// Throughput: one operation per cycle; every cell of the chain shifts in parallel,
// so the only limit is the single result register when the downstream side stalls.
// Reset: arst_n clears the stored length and the result valid flag at once;
// cell contents stay undefined and are never shown before they are written.
module positional_insert_deque
	import posdq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op [2:0], value [34:3], position [39:35]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status [1:0], count [6:2], front_value [38:7], back_value [70:39], zero [71]
	output logic [71:0] m_tdata
);

	// Unpack the incoming operation.
	logic [OP_W-1:0]          in_op;
	logic signed [DATA_W-1:0] in_value;
	logic [POS_W-1:0]         in_pos;

	assign in_op    = s_tdata[2:0];
	assign in_value = s_tdata[34:3];
	assign in_pos   = s_tdata[39:35];

	logic [CNT_W-1:0]  count_q;
	logic [STAT_W-1:0] status_q;
	logic              m_tvalid_q;
	logic              accept;

	// The result shown on the master side is taken straight from the stored
	// length and the end cells, so no new operation may be taken while a
	// result is still waiting; one that leaves in the same cycle frees the slot.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Decide what the operation does: where the chain opens or closes and how
	// the length moves.
	logic              full;
	logic              empty;
	logic              do_put;
	logic              do_take_front;
	logic              do_take_back;
	logic [CNT_W-1:0]  where;
	logic [STAT_W-1:0] status_d;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		do_put        = 1'b0;
		do_take_front = 1'b0;
		do_take_back  = 1'b0;
		where         = '0;
		status_d      = ST_OK;
		case (in_op)
			OP_ADD_FRONT: begin
				if (full) status_d = ST_FULL;
				else do_put = 1'b1;
			end
			OP_ADD_BACK: begin
				where = count_q;
				if (full) status_d = ST_FULL;
				else do_put = 1'b1;
			end
			OP_REMOVE_FRONT: begin
				if (empty) status_d = ST_EMPTY;
				else do_take_front = 1'b1;
			end
			OP_REMOVE_BACK: begin
				if (empty) status_d = ST_EMPTY;
				else do_take_back = 1'b1;
			end
			OP_INSERT: begin
				where = CNT_W'(in_pos);
				// The position is checked before the full condition.
				if (POS_W'(count_q) < in_pos) status_d = ST_RANGE;
				else if (full) status_d = ST_FULL;
				else do_put = 1'b1;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Cell chain. A put opens a gap at the target: cells above it take their
	// left neighbor and the target takes the new value. A front removal moves
	// every cell one step toward the front. Removing at the back only shortens
	// the length. Cells beyond the length may take anything; they are unread.
	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	cell_ctrl_t               cell_ctrl  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_left
			assign left_v = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_mid_right
			assign right_v = cell_value[i+1];
		end

		always_comb begin
			cell_ctrl[i].en  = accept && (do_put || do_take_front);
			cell_ctrl[i].sel = SEL_HOLD;
			if (do_put) begin
				if (where == CNT_W'(i)) cell_ctrl[i].sel = SEL_NEW;
				else if (where < CNT_W'(i)) cell_ctrl[i].sel = SEL_LEFT;
			end else if (do_take_front) begin
				cell_ctrl[i].sel = SEL_RIGHT;
			end
		end

		posdq_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl[i]),
			.new_value   (in_value),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[i])
		);
	end

	// Length, status and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			status_q   <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				status_q   <= status_d;
				m_tvalid_q <= 1'b1;
				if (do_put) count_q <= count_q + 1'b1;
				else if (do_take_front || do_take_back) count_q <= count_q - 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Front and back values follow the current state, which stays still while
	// a result waits. The back is the cell just below the length.
	logic [CNT_W-1:0]         back_ptr;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;

	assign back_ptr    = count_q - 1'b1;
	assign front_value = empty ? '0 : cell_value[0];
	assign back_value  = empty ? '0 : cell_value[back_ptr[IDX_W-1:0]];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, back_value, front_value, count_q, status_q};

	// The stored length never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored length exceeds capacity");

	// The length only moves on a transferred operation.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("stored length changed without a transfer");

	// A full status is only reported with the sequence at capacity.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == ST_FULL) |-> full)
		else $error("full status reported below capacity");

	// A waiting result blocks the input side.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !s_tready)
		else $error("input taken while a result waits");

endmodule
